FILE: rtl/telemetry_delta_text_encoder_defines.svh
// assertion macros for the telemetry delta text encoder
// used by the queue and the character serializer; no other dependencies
`ifndef TELEMETRY_DELTA_TEXT_ENCODER_DEFINES_SVH
`define TELEMETRY_DELTA_TEXT_ENCODER_DEFINES_SVH
`ifndef SYNTH
`define TDE_ASSERT_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("tde assertion failed");
`define TDE_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("tde assertion failed");
`else
`define TDE_ASSERT_IMPLY(name, clk, rst, cond, expr)
`define TDE_ASSERT_NEXT(name, clk, rst, cond, expr)
`endif
`endif

FILE: rtl/tde_pkg.sv
// shared types, constants and character helpers of the telemetry delta text encoder
// no dependencies
`timescale 1ns / 1ps

package tde_pkg;

   localparam int SLOT_COUNT  = 12;
   localparam int SLOT_W      = 4;
   localparam int VALUE_W     = 10;
   localparam int CHAR_W      = 7;
   localparam int MASK_W      = 9;
   localparam int NUM_SAMPLES = 7;
   localparam int DIFF_W      = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // slot order of one record
   localparam int SLOT_CLOCK_HI = 0;
   localparam int SLOT_CLOCK    = 1;
   localparam int SLOT_MODE     = 2;
   localparam int SLOT_REBOOT   = 3;
   localparam int SLOT_SAMPLE0  = 4;
   localparam int SLOT_RETURN   = 11;

   // include mask bits
   localparam int MASK_MODE    = 0;
   localparam int MASK_REBOOT  = 1;
   localparam int MASK_SAMPLE0 = 2;

   localparam logic [MASK_W-1:0]  MASK_RESET   = 9'd511;
   localparam logic [2:0]         GROUP_DIFFS  = 3'd7;
   localparam logic [2:0]         MODE_COUNT   = 3'd4;
   localparam logic [VALUE_W-1:0] MODE_UNKNOWN = 10'd23;
   localparam logic [DIFF_W-1:0]  DIFF_BIAS    = 16'd14;
   localparam logic [DIFF_W-1:0]  DIGIT_MAX    = 16'd31;
   localparam logic [4:0]         LETTER_COUNT = 5'd26;
   localparam logic [CHAR_W-1:0]  LETTER_LOW   = 7'd97;
   localparam logic [CHAR_W-1:0]  LETTER_HIGH  = 7'd39;
   localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 7'd32;
   localparam logic [CHAR_W-1:0]  CHAR_CR      = 7'd13;

   typedef enum logic [1:0] {
      KIND_DIGIT      = 2'd0,
      KIND_PAIR       = 2'd1,
      KIND_SPACE_PAIR = 2'd2,
      KIND_RETURN     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [VALUE_W-1:0]  value;
   } slot_type;

   typedef struct packed {
      logic [SLOT_COUNT-1:0]     en;
      slot_type [SLOT_COUNT-1:0] slot;
   } entry_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [4:0] d);
      if (d < LETTER_COUNT) begin
         return {2'b00, d} + LETTER_LOW;
      end else begin
         return {2'b00, d} + LETTER_HIGH;
      end
   endfunction

   function automatic slot_type diff_slot(input logic [DIFF_W-1:0] now,
                                          input logic [DIFF_W-1:0] old);
      logic [DIFF_W-1:0] d;
      slot_type          s;
      d = now - old + DIFF_BIAS;
      if (d <= DIGIT_MAX) begin
         s.kind  = KIND_DIGIT;
         s.value = {5'b00000, d[4:0]};
      end else begin
         s.kind  = KIND_SPACE_PAIR;
         s.value = now[VALUE_W-1:0];
      end
      return s;
   endfunction

endpackage

FILE: rtl/telemetry_delta_text_encoder.sv
// top level of the telemetry delta text encoder
// instantiates tde_front, tde_queue and tde_back; uses tde_pkg
`timescale 1ns / 1ps

// Each accepted record comes out as ASCII characters, one per cycle on the rsp
// channel while rsp_ready holds, with last_of_item on the final character of the
// record. A full record has 4 to 31 characters and a difference record 1 to 31.
// The front end classifies a record in the cycle it is accepted and a two-entry
// queue holds classified records, so up to two transactions are taken while
// earlier characters still drain. The user writes include_mask on the csr port
// only while the block is idle; the block does not enforce this. The csr port
// is always ready.
module telemetry_delta_text_encoder #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tde_pkg::MASK_W-1:0]   csr_include_mask,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_first_of_dump,
   input  logic [15:0]                  req_clock_count,
   input  logic [2:0]                   req_mode_code,
   input  logic [7:0]                   req_reboot_count,
   input  logic [SAMPLE_BITS-1:0]       req_psk_level,
   input  logic [SAMPLE_BITS-1:0]       req_agc_level,
   input  logic [SAMPLE_BITS-1:0]       req_battery_level,
   input  logic [SAMPLE_BITS-1:0]       req_supply_level,
   input  logic [SAMPLE_BITS-1:0]       req_current_level,
   input  logic [SAMPLE_BITS-1:0]       req_rx_temperature,
   input  logic [SAMPLE_BITS-1:0]       req_tx_temperature,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tde_pkg::CHAR_W-1:0]   rsp_out_char,
   output logic                         rsp_last_of_item
);
   import tde_pkg::*;

   logic      q_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head;

   assign csr_ready = 1'b1;

   tde_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_include_mask   (csr_include_mask),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_of_dump  (req_first_of_dump),
      .req_clock_count    (req_clock_count),
      .req_mode_code      (req_mode_code),
      .req_reboot_count   (req_reboot_count),
      .req_psk_level      (req_psk_level),
      .req_agc_level      (req_agc_level),
      .req_battery_level  (req_battery_level),
      .req_supply_level   (req_supply_level),
      .req_current_level  (req_current_level),
      .req_rx_temperature (req_rx_temperature),
      .req_tx_temperature (req_tx_temperature),
      .q_full             (q_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   tde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   tde_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (head_valid),
      .q_head           (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

FILE: rtl/tde_front.sv
// front end: accepts records, holds the previous record and group count,
// and classifies every field into a slot entry; uses tde_pkg
`timescale 1ns / 1ps

module tde_front #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [tde_pkg::MASK_W-1:0]   csr_include_mask,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_first_of_dump,
   input  logic [15:0]                  req_clock_count,
   input  logic [2:0]                   req_mode_code,
   input  logic [7:0]                   req_reboot_count,
   input  logic [SAMPLE_BITS-1:0]       req_psk_level,
   input  logic [SAMPLE_BITS-1:0]       req_agc_level,
   input  logic [SAMPLE_BITS-1:0]       req_battery_level,
   input  logic [SAMPLE_BITS-1:0]       req_supply_level,
   input  logic [SAMPLE_BITS-1:0]       req_current_level,
   input  logic [SAMPLE_BITS-1:0]       req_rx_temperature,
   input  logic [SAMPLE_BITS-1:0]       req_tx_temperature,
   input  logic                         q_full,
   output logic                         push,
   output tde_pkg::entry_type           push_entry
);
   import tde_pkg::*;

   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic [15:0]            prev_clock_ff;
   logic [2:0]             prev_mode_ff;
   logic [7:0]             prev_reboot_ff;
   logic [SAMPLE_BITS-1:0] prev_sample_ff [NUM_SAMPLES];
   logic [2:0]             diffs_left_ff, diffs_left_in;
   logic [SAMPLE_BITS-1:0] sample [NUM_SAMPLES];
   logic [DIFF_W-1:0]      sample_ext [NUM_SAMPLES];
   logic [DIFF_W-1:0]      prev_ext [NUM_SAMPLES];
   logic                   full_rec;

   assign sample[0] = req_psk_level;
   assign sample[1] = req_agc_level;
   assign sample[2] = req_battery_level;
   assign sample[3] = req_supply_level;
   assign sample[4] = req_current_level;
   assign sample[5] = req_rx_temperature;
   assign sample[6] = req_tx_temperature;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;
   assign mask_in   = csr_valid ? csr_include_mask : mask_ff;
   assign full_rec  = req_first_of_dump || (diffs_left_ff == 3'd0);

   always_comb begin
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         sample_ext[i] = DIFF_W'(sample[i]);
         prev_ext[i]   = DIFF_W'(prev_sample_ff[i]);
      end
      push_entry = '0;
      if (full_rec) begin
         diffs_left_in = GROUP_DIFFS;
         push_entry.en[SLOT_CLOCK_HI]   = 1'b1;
         push_entry.slot[SLOT_CLOCK_HI] = '{kind: KIND_PAIR,
                                           value: {4'b0000, req_clock_count[15:10]}};
         push_entry.en[SLOT_CLOCK]      = 1'b1;
         push_entry.slot[SLOT_CLOCK]    = '{kind: KIND_PAIR,
                                           value: req_clock_count[VALUE_W-1:0]};
         push_entry.en[SLOT_MODE]       = mask_ff[MASK_MODE];
         push_entry.slot[SLOT_MODE]     = '{kind: KIND_SPACE_PAIR,
                                           value: (req_mode_code < MODE_COUNT) ?
                                                  {7'b0000000, req_mode_code} :
                                                  MODE_UNKNOWN};
         push_entry.en[SLOT_REBOOT]     = mask_ff[MASK_REBOOT];
         push_entry.slot[SLOT_REBOOT]   = '{kind: KIND_SPACE_PAIR,
                                           value: {2'b00, req_reboot_count}};
         for (int i = 0; i < NUM_SAMPLES; i++) begin
            push_entry.en[SLOT_SAMPLE0+i]   = mask_ff[MASK_SAMPLE0+i];
            push_entry.slot[SLOT_SAMPLE0+i] = '{kind: KIND_SPACE_PAIR,
                                               value: sample_ext[i][VALUE_W-1:0]};
         end
      end else begin
         diffs_left_in = diffs_left_ff - 3'd1;
         push_entry.en[SLOT_CLOCK]    = 1'b1;
         push_entry.slot[SLOT_CLOCK]  = diff_slot(req_clock_count, prev_clock_ff);
         push_entry.en[SLOT_MODE]     = mask_ff[MASK_MODE];
         push_entry.slot[SLOT_MODE]   = diff_slot({13'b0, req_mode_code},
                                                  {13'b0, prev_mode_ff});
         push_entry.en[SLOT_REBOOT]   = mask_ff[MASK_REBOOT];
         push_entry.slot[SLOT_REBOOT] = diff_slot({8'b0, req_reboot_count},
                                                  {8'b0, prev_reboot_ff});
         for (int i = 0; i < NUM_SAMPLES; i++) begin
            push_entry.en[SLOT_SAMPLE0+i]   = mask_ff[MASK_SAMPLE0+i];
            push_entry.slot[SLOT_SAMPLE0+i] = diff_slot(sample_ext[i], prev_ext[i]);
         end
         // group ends after the seventh difference record
         push_entry.en[SLOT_RETURN]   = (diffs_left_ff == 3'd1);
         push_entry.slot[SLOT_RETURN] = '{kind: KIND_RETURN, value: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= MASK_RESET;
         prev_clock_ff  <= '0;
         prev_mode_ff   <= '0;
         prev_reboot_ff <= '0;
         diffs_left_ff  <= '0;
         for (int i = 0; i < NUM_SAMPLES; i++) begin
            prev_sample_ff[i] <= '0;
         end
      end else begin
         mask_ff <= mask_in;
         if (push) begin
            prev_clock_ff  <= req_clock_count;
            prev_mode_ff   <= req_mode_code;
            prev_reboot_ff <= req_reboot_count;
            diffs_left_ff  <= diffs_left_in;
            for (int i = 0; i < NUM_SAMPLES; i++) begin
               prev_sample_ff[i] <= sample[i];
            end
         end
      end
   end

endmodule

FILE: rtl/tde_queue.sv
// short queue of classified records between the front end and the serializer
// uses tde_pkg and the assertion macros of telemetry_delta_text_encoder_defines.svh
`timescale 1ns / 1ps
`include "telemetry_delta_text_encoder_defines.svh"

module tde_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tde_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output tde_pkg::entry_type  head
);
   import tde_pkg::*;

   entry_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `TDE_ASSERT_IMPLY(a_push_not_full, clock, reset, push, !full)
   `TDE_ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, head_valid)
   `TDE_ASSERT_NEXT(a_fills_up, clock, reset, push && !pop && count_ff == COUNT_W'(QUEUE_DEPTH - 1), full)

endmodule

FILE: rtl/tde_back.sv
// serializer: walks the queue head slots, sends one character per cycle through the
// output register when free; uses tde_pkg and telemetry_delta_text_encoder_defines.svh
`timescale 1ns / 1ps
`include "telemetry_delta_text_encoder_defines.svh"

module tde_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  tde_pkg::entry_type          q_head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tde_pkg::CHAR_W-1:0]  rsp_out_char,
   output logic                        rsp_last_of_item
);
   import tde_pkg::*;

   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     char_ff;
   logic                  last_ff;
   logic [SLOT_W-1:0]     cur;
   logic                  found;
   logic [SLOT_COUNT-1:0] above;
   slot_type              cur_slot;
   logic                  last_phase;
   logic                  item_done;
   logic                  out_free;
   logic                  emit;
   logic [CHAR_W-1:0]     hi_char, lo_char, next_char;

   // lowest enabled slot at or after the current position
   always_comb begin
      found = 1'b0;
      cur   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (q_head.en[i] && (SLOT_W'(i) >= slot_ff)) begin
            found = 1'b1;
            cur   = SLOT_W'(i);
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         above[i] = q_head.en[i] && (SLOT_W'(i) > cur);
      end
   end

   assign cur_slot = q_head.slot[cur];
   assign hi_char  = digit_char(cur_slot.value[9:5]);
   assign lo_char  = digit_char(cur_slot.value[4:0]);

   always_comb begin
      case (cur_slot.kind)
         KIND_DIGIT: begin
            last_phase = (phase_ff == 2'd0);
            next_char  = lo_char;
         end
         KIND_PAIR: begin
            last_phase = (phase_ff == 2'd1);
            next_char  = (phase_ff == 2'd0) ? hi_char : lo_char;
         end
         KIND_SPACE_PAIR: begin
            last_phase = (phase_ff == 2'd2);
            next_char  = (phase_ff == 2'd0) ? CHAR_SPACE :
                         (phase_ff == 2'd1) ? hi_char : lo_char;
         end
         KIND_RETURN: begin
            last_phase = (phase_ff == 2'd0);
            next_char  = CHAR_CR;
         end
         default: begin
            last_phase = 1'b1;
            next_char  = CHAR_CR;
         end
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = q_valid && out_free;
   assign item_done = last_phase && !(|above);
   assign pop       = emit && item_done;

   always_comb begin
      slot_in      = slot_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         if (item_done) begin
            slot_in  = '0;
            phase_in = '0;
         end else if (last_phase) begin
            slot_in  = cur + SLOT_W'(1);
            phase_in = '0;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= next_char;
         last_ff <= item_done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_last_of_item = last_ff;

   `TDE_ASSERT_IMPLY(a_slot_found, clock, reset, emit, found)
   `TDE_ASSERT_NEXT(a_pop_rewinds, clock, reset, pop, slot_ff == '0 && phase_ff == 2'd0)
   `TDE_ASSERT_IMPLY(a_cr_is_last, clock, reset, rsp_valid_ff && char_ff == CHAR_CR, last_ff)

endmodule

FILE: dv/testbench.sv
// self-checking testbench for telemetry_delta_text_encoder: a scoreboard class predicts
// the characters of every accepted record and checks each rsp transaction in order
// depends on tde_pkg and the rtl of the encoder
`timescale 1ns / 1ps

typedef struct packed {
   logic                                                 first;
   logic [15:0]                                          stamp;
   logic [2:0]                                           mode;
   logic [7:0]                                           reboot;
   logic [tde_pkg::NUM_SAMPLES-1:0][tde_pkg::VALUE_W-1:0] level;
} record_type;

typedef struct packed {
   logic [tde_pkg::CHAR_W-1:0] code;
   logic                       last;
} text_char_type;

class text_scoreboard;
   logic [tde_pkg::MASK_W-1:0]                           field_mask;
   logic [15:0]                                          last_stamp;
   logic [2:0]                                           last_mode;
   logic [7:0]                                           last_reboot;
   logic [tde_pkg::NUM_SAMPLES-1:0][tde_pkg::VALUE_W-1:0] last_level;
   int unsigned                                          diffs_left;
   text_char_type                                        expected_chars[$];
   text_char_type                                        record_chars[$];
   int unsigned                                          mismatches;

   function new();
      field_mask  = tde_pkg::MASK_RESET;
      last_stamp  = '0;
      last_mode   = '0;
      last_reboot = '0;
      last_level  = '0;
      diffs_left  = 0;
      mismatches  = 0;
   endfunction

   function void set_mask(input logic [tde_pkg::MASK_W-1:0] m);
      field_mask = m;
   endfunction

   // base-32 digit: lower-case letters first, then upper-case from A
   function logic [tde_pkg::CHAR_W-1:0] letter_of(input logic [4:0] d);
      logic [7:0] c;
      if (d < 5'd26) begin
         c = 8'h61 + {3'b000, d};
      end else begin
         c = 8'h41 + {3'b000, d} - 8'd26;
      end
      return c[tde_pkg::CHAR_W-1:0];
   endfunction

   function void put(input logic [tde_pkg::CHAR_W-1:0] c);
      text_char_type t;
      t.code = c;
      t.last = 1'b0;
      record_chars.push_back(t);
   endfunction

   function void put_pair(input logic [tde_pkg::VALUE_W-1:0] v);
      put(letter_of(v[9:5]));
      put(letter_of(v[4:0]));
   endfunction

   function void put_delta(input logic [15:0] now, input logic [15:0] old);
      logic [15:0] d;
      d = now - old + tde_pkg::DIFF_BIAS;
      if (d <= 16'd31) begin
         put(letter_of(d[4:0]));
      end else begin
         put(tde_pkg::CHAR_SPACE);
         put_pair(now[tde_pkg::VALUE_W-1:0]);
      end
   endfunction

   function void note_record(input record_type r);
      text_char_type t;
      int            i;
      record_chars.delete();
      if (r.first) begin
         diffs_left = 0;
      end
      if (diffs_left == 0) begin
         put_pair({4'b0000, r.stamp[15:10]});
         put_pair(r.stamp[9:0]);
         if (field_mask[0]) begin
            put(tde_pkg::CHAR_SPACE);
            put_pair((r.mode < tde_pkg::MODE_COUNT) ? {7'b0, r.mode} : tde_pkg::MODE_UNKNOWN);
         end
         if (field_mask[1]) begin
            put(tde_pkg::CHAR_SPACE);
            put_pair({2'b00, r.reboot});
         end
         for (i = 0; i < tde_pkg::NUM_SAMPLES; i++) begin
            if (field_mask[2 + i]) begin
               put(tde_pkg::CHAR_SPACE);
               put_pair(r.level[i]);
            end
         end
         diffs_left = tde_pkg::GROUP_DIFFS;
      end else begin
         put_delta(r.stamp, last_stamp);
         if (field_mask[0]) begin
            put_delta({13'b0, r.mode}, {13'b0, last_mode});
         end
         if (field_mask[1]) begin
            put_delta({8'b0, r.reboot}, {8'b0, last_reboot});
         end
         for (i = 0; i < tde_pkg::NUM_SAMPLES; i++) begin
            if (field_mask[2 + i]) begin
               put_delta({6'b0, r.level[i]}, {6'b0, last_level[i]});
            end
         end
         diffs_left = diffs_left - 1;
         if (diffs_left == 0) begin
            put(tde_pkg::CHAR_CR);
         end
      end
      last_stamp  = r.stamp;
      last_mode   = r.mode;
      last_reboot = r.reboot;
      last_level  = r.level;
      foreach (record_chars[k]) begin
         t = record_chars[k];
         t.last = (k == record_chars.size() - 1);
         expected_chars.push_back(t);
      end
   endfunction

   function void check_char(input logic [tde_pkg::CHAR_W-1:0] c, input logic last);
      text_char_type t;
      if (expected_chars.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected character: out_char %0d last_of_item %0b", c, last);
         end
      end else begin
         t = expected_chars.pop_front();
         if (c !== t.code || last !== t.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("character mismatch: out_char exp %0d act %0d, %s %0b act %0b",
                        t.code, c, "last_of_item exp", t.last, last);
            end
         end
      end
   endfunction
endclass

module testbench;

   localparam int CLOCK_PERIOD = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [tde_pkg::MASK_W-1:0]     csr_include_mask;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_first_of_dump;
   logic [15:0]                    req_clock_count;
   logic [2:0]                     req_mode_code;
   logic [7:0]                     req_reboot_count;
   logic [tde_pkg::VALUE_W-1:0]    req_psk_level;
   logic [tde_pkg::VALUE_W-1:0]    req_agc_level;
   logic [tde_pkg::VALUE_W-1:0]    req_battery_level;
   logic [tde_pkg::VALUE_W-1:0]    req_supply_level;
   logic [tde_pkg::VALUE_W-1:0]    req_current_level;
   logic [tde_pkg::VALUE_W-1:0]    req_rx_temperature;
   logic [tde_pkg::VALUE_W-1:0]    req_tx_temperature;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [tde_pkg::CHAR_W-1:0]     rsp_out_char;
   logic                           rsp_last_of_item;

   text_scoreboard sb;
   record_type     last_sent;
   int unsigned    send_idle_pct = 0;
   int unsigned    rsp_stall_pct = 0;
   int unsigned    hold_requests = 0;
   int unsigned    holds_served  = 0;
   int unsigned    hold_left     = 0;
   int unsigned    cycle_count   = 0;

   telemetry_delta_text_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_include_mask   (csr_include_mask),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_of_dump  (req_first_of_dump),
      .req_clock_count    (req_clock_count),
      .req_mode_code      (req_mode_code),
      .req_reboot_count   (req_reboot_count),
      .req_psk_level      (req_psk_level),
      .req_agc_level      (req_agc_level),
      .req_battery_level  (req_battery_level),
      .req_supply_level   (req_supply_level),
      .req_current_level  (req_current_level),
      .req_rx_temperature (req_rx_temperature),
      .req_tx_temperature (req_tx_temperature),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_item   (rsp_last_of_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("telemetry_delta_text_encoder: mismatch");
         $finish;
      end
   end

   // result side: check, then pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_char(rsp_out_char, rsp_last_of_item);
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            rsp_ready    <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic record_type make_record(input logic first, input logic [15:0] stamp,
                                              input logic [2:0] mode, input logic [7:0] reboot,
                                              input int lvl, input int step);
      record_type r;
      int         i;
      r.first  = first;
      r.stamp  = stamp;
      r.mode   = mode;
      r.reboot = reboot;
      for (i = 0; i < tde_pkg::NUM_SAMPLES; i++) begin
         r.level[i] = 10'(lvl + i * step);
      end
      return r;
   endfunction

   // mostly small steps from the last record so groups stay compact, some noise
   function automatic record_type next_record(input record_type base);
      record_type r;
      int         i;
      r = base;
      r.first = ($urandom_range(11) == 0);
      if ($urandom_range(99) < 12) begin
         r.stamp  = 16'($urandom);
         r.mode   = 3'($urandom);
         r.reboot = 8'($urandom);
         for (i = 0; i < tde_pkg::NUM_SAMPLES; i++) begin
            r.level[i] = 10'($urandom);
         end
      end else begin
         r.stamp = base.stamp + 16'($urandom_range(33)) - 16'd14;
         if ($urandom_range(3) == 0) begin
            r.mode = 3'($urandom);
         end
         if ($urandom_range(7) == 0) begin
            r.reboot = base.reboot + 8'($urandom_range(33)) - 8'd14;
         end
         for (i = 0; i < tde_pkg::NUM_SAMPLES; i++) begin
            r.level[i] = base.level[i] + 10'($urandom_range(35)) - 10'd16;
         end
      end
      return r;
   endfunction

   task automatic send_record(input record_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_first_of_dump  <= r.first;
      req_clock_count    <= r.stamp;
      req_mode_code      <= r.mode;
      req_reboot_count   <= r.reboot;
      req_psk_level      <= r.level[0];
      req_agc_level      <= r.level[1];
      req_battery_level  <= r.level[2];
      req_supply_level   <= r.level[3];
      req_current_level  <= r.level[4];
      req_rx_temperature <= r.level[5];
      req_tx_temperature <= r.level[6];
      do @(posedge clock); while (!req_ready);
      sb.note_record(r);
      last_sent = r;
   endtask

   task automatic write_mask(input logic [tde_pkg::MASK_W-1:0] m);
      csr_valid        <= 1'b1;
      csr_include_mask <= m;
      do @(posedge clock); while (!csr_ready);
      sb.set_mask(m);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random(input int count, input int hold_at);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) begin
            hold_requests <= hold_requests + 1;
         end
         send_record(next_record(last_sent));
      end
   endtask

   task automatic start_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      send_idle_pct <= idle_pct;
      rsp_stall_pct <= stall_pct;
      @(posedge clock);
   endtask

   initial begin
      sb = new();
      reset              <= 1'b1;
      csr_valid          <= 1'b0;
      csr_include_mask   <= '0;
      req_valid          <= 1'b0;
      req_first_of_dump  <= 1'b0;
      req_clock_count    <= '0;
      req_mode_code      <= '0;
      req_reboot_count   <= '0;
      req_psk_level      <= '0;
      req_agc_level      <= '0;
      req_battery_level  <= '0;
      req_supply_level   <= '0;
      req_current_level  <= '0;
      req_rx_temperature <= '0;
      req_tx_temperature <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset mask, no idling: group boundaries, digit limits, wrap, unknown modes
      send_record(make_record(1'b1, 16'd0, 3'd0, 8'd0, 0, 0));
      send_record(make_record(1'b0, 16'd0, 3'd0, 8'd0, 0, 0));
      send_record(make_record(1'b0, 16'd17, 3'd7, 8'd17, 17, 0));
      send_record(make_record(1'b0, 16'd3, 3'd0, 8'd3, 3, 0));
      send_record(make_record(1'b0, 16'd21, 3'd1, 8'd21, 21, 0));
      send_record(make_record(1'b0, 16'd6, 3'd2, 8'd6, 6, 0));
      send_record(make_record(1'b0, 16'd65535, 3'd5, 8'd255, 1023, 0));
      send_record(make_record(1'b0, 16'd4, 3'd4, 8'd0, 1023, 0));
      send_record(make_record(1'b0, 16'd65535, 3'd6, 8'd255, 1023, 0));
      send_record(make_record(1'b0, 16'd9, 3'd3, 8'd254, 1000, 0));
      send_record(make_record(1'b1, 16'd40000, 3'd7, 8'd128, 512, 0));
      send_record(make_record(1'b1, 16'd40000, 3'd1, 8'd128, 500, 3));
      send_record(make_record(1'b0, 16'd40017, 3'd0, 8'd145, 517, 3));
      send_record(make_record(1'b0, 16'd40003, 3'd3, 8'd131, 503, 3));
      send_record(make_record(1'b0, 16'd40003, 3'd2, 8'd131, 0, 146));
      send_record(make_record(1'b1, 16'd1023, 3'd4, 8'd255, 1023, 0));
      send_record(make_record(1'b1, 16'd1024, 3'd5, 8'd1, 0, 170));
      send_record(make_record(1'b1, 16'd2, 3'd2, 8'd2, 2, 0));
      send_record(make_record(1'b1, 16'd3, 3'd3, 8'd3, 3, 0));
      send_record(make_record(1'b1, 16'd1, 3'd1, 8'd1, 1, 0));
      send_random(80, 20);
      drain();

      write_mask('0);
      start_phase(64, 0);
      send_random(40, -1);
      drain();

      write_mask(tde_pkg::MASK_RESET);
      start_phase(0, 64);
      send_random(70, -1);
      drain();

      write_mask(9'h0AA);
      start_phase(15, 15);
      send_random(50, -1);
      drain();

      write_mask(9'($urandom));
      start_phase(15, 15);
      send_random(50, -1);
      drain();

      write_mask(9'h155);
      start_phase(0, 0);
      send_random(40, -1);
      drain();

      if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
         $display("telemetry_delta_text_encoder: match");
      end else begin
         $display("telemetry_delta_text_encoder: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tde_pkg.sv
rtl/tde_front.sv
rtl/tde_queue.sv
rtl/tde_back.sv
rtl/telemetry_delta_text_encoder.sv
dv/testbench.sv
